FILE: design/alcc_pkg.sv
`default_nettype none
package alcc_pkg;

  // Field widths of the time and alarm registers.
  localparam int unsigned HourW     = 5;
  localparam int unsigned MinW      = 6;
  localparam int unsigned SecW      = 6;
  localparam int unsigned TickW     = 16;
  localparam int unsigned ButtonW   = 4;

  localparam logic [MinW-1:0] HoursPerDay      = MinW'(24);
  localparam logic [MinW-1:0] MinutesPerHour   = MinW'(60);
  localparam logic [MinW-1:0] SecondsPerMinute = MinW'(60);

  localparam logic [TickW-1:0] TicksReset = TickW'(23500);

  localparam logic [HourW-1:0] HourReset   = HourW'(11);
  localparam logic [MinW-1:0]  MinuteReset = MinW'(30);
  localparam logic [SecW-1:0]  SecondReset = SecW'(55);

  // Bit positions in the active-low button sample.
  localparam int unsigned BtnHour   = 0;
  localparam int unsigned BtnMinute = 1;
  localparam int unsigned BtnClear  = 2;
  localparam int unsigned BtnToggle = 3;

  typedef enum logic {
    OpTick    = 1'b0,
    OpButtons = 1'b1
  } op_t;

  // Increment with wrap to zero at the given limit.
  function automatic logic [MinW-1:0] inc_wrap(input logic [MinW-1:0] v,
                                               input logic [MinW-1:0] limit);
    logic [MinW-1:0] s;
    s = v + MinW'(1);
    return (s >= limit) ? '0 : s;
  endfunction

endpackage
`default_nettype wire

FILE: design/alarm_clock_counter.sv
`default_nettype none
// Time-of-day clock with a wake-up alarm.
//
// Input channel (in_valid/in_ready): each transfer carries either a timer tick
// (in_operation low) or a sample of four active-low buttons (in_operation high).
// Every accepted item produces exactly one result on the output channel
// (out_valid/out_ready), showing the time, the alarm setting, whether the alarm
// is armed and whether it is ringing, all as they stand after that item.
//
// The result of an item accepted at a clock edge is registered and presented from
// the next edge onwards. The block accepts one item every clock while the receiver
// keeps up; the clock state and the result register are updated in the same cycle,
// so the only limit is the single result register. When the receiver stalls, the
// result is held and input is taken only in a cycle in which the held result is
// transferred at the same edge, so nothing is lost.
//
// The configuration channel (cfg_valid/cfg_ready) writes ticks_per_second and
// is always ready. Reset sets the time to 11:30:55, clears the alarm setting
// and the prescaler, disarms the alarm and loads 23500 ticks per second.
module alarm_clock_counter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [alcc_pkg::TickW-1:0]    cfg_ticks_per_second,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          in_operation,
  input  wire logic [alcc_pkg::ButtonW-1:0]  in_buttons,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [alcc_pkg::HourW-1:0]    out_hours,
  output      logic [alcc_pkg::MinW-1:0]     out_minutes,
  output      logic [alcc_pkg::SecW-1:0]     out_seconds,
  output      logic [alcc_pkg::HourW-1:0]    out_wake_hours,
  output      logic [alcc_pkg::MinW-1:0]     out_wake_minutes,
  output      logic                          out_armed,
  output      logic                          out_ringing
);
  import alcc_pkg::*;

  // Clock state.
  logic [TickW-1:0] tps_r;
  logic [TickW-1:0] prescale_r, prescale_nxt;
  logic [HourW-1:0] hour_r, hour_nxt;
  logic [MinW-1:0]  minute_r, minute_nxt;
  logic [SecW-1:0]  second_r, second_nxt;
  logic [HourW-1:0] wake_hour_r, wake_hour_nxt;
  logic [MinW-1:0]  wake_minute_r, wake_minute_nxt;
  logic             armed_r, armed_nxt;
  logic             ringing_nxt;

  // Result register.
  logic             out_valid_r;
  logic [HourW-1:0] out_hours_r;
  logic [MinW-1:0]  out_minutes_r;
  logic [SecW-1:0]  out_seconds_r;
  logic [HourW-1:0] out_wake_hours_r;
  logic [MinW-1:0]  out_wake_minutes_r;
  logic             out_armed_r;
  logic             out_ringing_r;

  logic               in_fire;
  logic [ButtonW-1:0] pressed;
  logic [TickW-1:0]   prescale_inc;
  logic               second_due;
  logic [SecW-1:0]    second_step;
  logic [MinW-1:0]    minute_step;
  logic [HourW-1:0]   hour_step;

  // The result register may be refilled in the cycle in which it is emptied.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign pressed      = ~in_buttons;
  assign prescale_inc = prescale_r + TickW'(1);
  assign second_due   = (prescale_inc == tps_r);

  // Carry chain of one second: seconds, then minutes, then hours.
  assign second_step = SecW'(inc_wrap(MinW'(second_r), SecondsPerMinute));
  assign minute_step = (second_step == '0) ? inc_wrap(minute_r, MinutesPerHour) : minute_r;
  assign hour_step   = ((second_step == '0) && (minute_step == '0))
                       ? HourW'(inc_wrap(MinW'(hour_r), HoursPerDay)) : hour_r;

  always_comb begin
    prescale_nxt    = prescale_r;
    hour_nxt        = hour_r;
    minute_nxt      = minute_r;
    second_nxt      = second_r;
    wake_hour_nxt   = wake_hour_r;
    wake_minute_nxt = wake_minute_r;
    armed_nxt       = armed_r;
    if (in_operation == OpTick) begin
      if (second_due) begin
        prescale_nxt = '0;
        second_nxt   = second_step;
        minute_nxt   = minute_step;
        hour_nxt     = hour_step;
      end else begin
        prescale_nxt = prescale_inc;
      end
    end else if (!armed_r) begin
      // Disarmed: the buttons set the clock and may arm the alarm.
      if (pressed[BtnHour]) begin
        hour_nxt = HourW'(inc_wrap(MinW'(hour_r), HoursPerDay));
      end
      if (pressed[BtnMinute]) begin
        minute_nxt = inc_wrap(minute_r, MinutesPerHour);
      end
      if (pressed[BtnClear]) begin
        second_nxt = '0;
      end
      if (pressed[BtnToggle]) begin
        armed_nxt = 1'b1;
      end
    end else begin
      // Armed: the buttons set the alarm and may disarm it.
      if (pressed[BtnHour]) begin
        wake_hour_nxt = HourW'(inc_wrap(MinW'(wake_hour_r), HoursPerDay));
      end
      if (pressed[BtnMinute]) begin
        wake_minute_nxt = inc_wrap(wake_minute_r, MinutesPerHour);
      end
      if (pressed[BtnToggle]) begin
        armed_nxt = 1'b0;
      end
    end
    ringing_nxt = armed_nxt && (hour_nxt == wake_hour_nxt) &&
                  (minute_nxt == wake_minute_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TicksReset;
    end else if (cfg_valid && cfg_ready) begin
      tps_r <= cfg_ticks_per_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r    <= '0;
      hour_r        <= HourReset;
      minute_r      <= MinuteReset;
      second_r      <= SecondReset;
      wake_hour_r   <= '0;
      wake_minute_r <= '0;
      armed_r       <= 1'b0;
    end else if (in_fire) begin
      prescale_r    <= prescale_nxt;
      hour_r        <= hour_nxt;
      minute_r      <= minute_nxt;
      second_r      <= second_nxt;
      wake_hour_r   <= wake_hour_nxt;
      wake_minute_r <= wake_minute_nxt;
      armed_r       <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_hours_r        <= hour_nxt;
      out_minutes_r      <= minute_nxt;
      out_seconds_r      <= second_nxt;
      out_wake_hours_r   <= wake_hour_nxt;
      out_wake_minutes_r <= wake_minute_nxt;
      out_armed_r        <= armed_nxt;
      out_ringing_r      <= ringing_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hours        = out_hours_r;
  assign out_minutes      = out_minutes_r;
  assign out_seconds      = out_seconds_r;
  assign out_wake_hours   = out_wake_hours_r;
  assign out_wake_minutes = out_wake_minutes_r;
  assign out_armed        = out_armed_r;
  assign out_ringing      = out_ringing_r;

  // The held time never leaves the range of a day.
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (MinW'(hour_r) < HoursPerDay) && (minute_r < MinutesPerHour) &&
    (MinW'(second_r) < SecondsPerMinute))
    else $error("clock register out of range");

  // A presented result rings only when the alarm is armed and the times agree.
  a_ring_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ringing_r == (out_armed_r && (out_hours_r == out_wake_hours_r) &&
                                       (out_minutes_r == out_wake_minutes_r))))
    else $error("ringing flag inconsistent with result");

  // A button sample never moves the prescaler.
  a_buttons_keep_prescaler: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_operation == OpButtons)) |=> $stable(prescale_r))
    else $error("prescaler changed on a button sample");

  // Every accepted item leaves a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid_r && (out_armed_r == armed_r)))
    else $error("accepted item left no result");

endmodule
`default_nettype wire

FILE: verif/alarm_clock_counter_checker.sv
module alarm_clock_counter_checker
  import alcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [TickW-1:0]   cfg_ticks_per_second,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_operation,
  input  logic [ButtonW-1:0] in_buttons,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [HourW-1:0]   out_hours,
  input  logic [MinW-1:0]    out_minutes,
  input  logic [SecW-1:0]    out_seconds,
  input  logic [HourW-1:0]   out_wake_hours,
  input  logic [MinW-1:0]    out_wake_minutes,
  input  logic               out_armed,
  input  logic               out_ringing,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    logic [HourW-1:0] wake_hours;
    logic [MinW-1:0]  wake_minutes;
    logic             armed;
    logic             ringing;
  } clock_view_t;

  logic [TickW-1:0] ticks_per_sec;
  logic [TickW-1:0] prescale;
  logic [HourW-1:0] hour_now;
  logic [MinW-1:0]  minute_now;
  logic [SecW-1:0]  second_now;
  logic [HourW-1:0] wake_hour_now;
  logic [MinW-1:0]  wake_minute_now;
  logic             armed_now;
  clock_view_t      pending_views [$];
  int unsigned      results_seen;

  function automatic int unsigned bump(input int unsigned value, input int unsigned limit);
    return (value + 1 >= limit) ? 0 : value + 1;
  endfunction

  // Applies one accepted item to the predicted clock and returns the view it should show.
  function automatic clock_view_t apply_item(input op_t op, input logic [ButtonW-1:0] raw);
    logic [ButtonW-1:0] pressed;
    clock_view_t view;
    pressed = ~raw;
    if (op == OpTick) begin
      prescale = prescale + 1'b1;
      if (prescale == ticks_per_sec) begin
        prescale = '0;
        second_now = SecW'(bump(second_now, SecondsPerMinute));
        if (second_now == '0) begin
          minute_now = MinW'(bump(minute_now, MinutesPerHour));
          if (minute_now == '0) begin
            hour_now = HourW'(bump(hour_now, HoursPerDay));
          end
        end
      end
    end else if (!armed_now) begin
      if (pressed[BtnHour]) hour_now = HourW'(bump(hour_now, HoursPerDay));
      if (pressed[BtnMinute]) minute_now = MinW'(bump(minute_now, MinutesPerHour));
      if (pressed[BtnClear]) second_now = '0;
      if (pressed[BtnToggle]) armed_now = 1'b1;
    end else begin
      if (pressed[BtnHour]) wake_hour_now = HourW'(bump(wake_hour_now, HoursPerDay));
      if (pressed[BtnMinute]) wake_minute_now = MinW'(bump(wake_minute_now, MinutesPerHour));
      if (pressed[BtnToggle]) armed_now = 1'b0;
    end
    view.hours        = hour_now;
    view.minutes      = minute_now;
    view.seconds      = second_now;
    view.wake_hours   = wake_hour_now;
    view.wake_minutes = wake_minute_now;
    view.armed        = armed_now;
    view.ringing      = armed_now && hour_now == wake_hour_now && minute_now == wake_minute_now;
    return view;
  endfunction

  function automatic string describe(input clock_view_t v);
    return $sformatf("%02d:%02d:%02d wake %02d:%02d armed %0b ringing %0b",
                     v.hours, v.minutes, v.seconds, v.wake_hours, v.wake_minutes,
                     v.armed, v.ringing);
  endfunction

  always @(posedge clk) begin : watch
    clock_view_t got;
    clock_view_t want;
    if (!rst_n) begin
      ticks_per_sec   = TicksReset;
      prescale        = '0;
      hour_now        = HourReset;
      minute_now      = MinuteReset;
      second_now      = SecondReset;
      wake_hour_now   = '0;
      wake_minute_now = '0;
      armed_now       = 1'b0;
      pending_views.delete();
    end else begin
      // The result transfer at this edge belongs to an item accepted earlier, so it is
      // matched before any item accepted at the same edge is queued.
      if (out_valid && out_ready) begin
        got.hours        = out_hours;
        got.minutes      = out_minutes;
        got.seconds      = out_seconds;
        got.wake_hours   = out_wake_hours;
        got.wake_minutes = out_wake_minutes;
        got.armed        = out_armed;
        got.ringing      = out_ringing;
        results_seen++;
        if (pending_views.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("%0t ns: result %0d arrived with none outstanding: %s",
                     $time, results_seen, describe(got));
          end
          mismatches++;
        end else begin
          want = pending_views.pop_front();
          if (got !== want) begin
            if (mismatches < ReportLimit) begin
              $display("%0t ns: result %0d expected %s, got %s",
                       $time, results_seen, describe(want), describe(got));
            end
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) ticks_per_sec = cfg_ticks_per_second;
      if (in_valid && in_ready) begin
        pending_views.push_back(apply_item(op_t'(in_operation), in_buttons));
      end
    end
    outstanding = pending_views.size();
  end

endmodule

FILE: verif/alarm_clock_counter_tb.sv
module alarm_clock_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import alcc_pkg::*;

  // Button masks are written active high here and inverted on the way into the block,
  // whose buttons read low when pressed.
  localparam logic [ButtonW-1:0] PressNone   = '0;
  localparam logic [ButtonW-1:0] PressAll    = '1;
  localparam logic [ButtonW-1:0] PressHour   = ButtonW'(1) << BtnHour;
  localparam logic [ButtonW-1:0] PressMinute = ButtonW'(1) << BtnMinute;
  localparam logic [ButtonW-1:0] PressClear  = ButtonW'(1) << BtnClear;
  localparam logic [ButtonW-1:0] PressToggle = ButtonW'(1) << BtnToggle;

  localparam logic [HourW-1:0] LastHour   = HourW'(HoursPerDay - 1);
  localparam logic [MinW-1:0]  LastMinute = MinW'(MinutesPerHour - 1);
  localparam int unsigned      MaxGap     = 18;
  localparam int unsigned      PhaseItems = 190;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [TickW-1:0]   cfg_ticks_per_second = TicksReset;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_operation = OpTick;
  logic [ButtonW-1:0] in_buttons = '1;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [HourW-1:0]   out_hours;
  logic [MinW-1:0]    out_minutes;
  logic [SecW-1:0]    out_seconds;
  logic [HourW-1:0]   out_wake_hours;
  logic [MinW-1:0]    out_wake_minutes;
  logic               out_armed;
  logic               out_ringing;

  int mismatches;
  int outstanding;

  // When set, neither side inserts gaps, so the block runs at one transfer per clock.
  logic             no_idle = 1'b0;
  logic [TickW-1:0] ticks_now = TicksReset;
  int unsigned      items_sent = 0;

  // The last result seen on the output channel. Sequences that steer the clock towards a
  // particular state look at these once every outstanding result has been transferred.
  logic [HourW-1:0] seen_hours;
  logic [MinW-1:0]  seen_minutes;
  logic [HourW-1:0] seen_wake_hours;
  logic [MinW-1:0]  seen_wake_minutes;
  logic             seen_armed = 1'b0;

  alarm_clock_counter dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_ticks_per_second (cfg_ticks_per_second),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_buttons           (in_buttons),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_hours            (out_hours),
    .out_minutes          (out_minutes),
    .out_seconds          (out_seconds),
    .out_wake_hours       (out_wake_hours),
    .out_wake_minutes     (out_wake_minutes),
    .out_armed            (out_armed),
    .out_ringing          (out_ringing)
  );

  alarm_clock_counter_checker clock_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_ticks_per_second (cfg_ticks_per_second),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_buttons           (in_buttons),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_hours            (out_hours),
    .out_minutes          (out_minutes),
    .out_seconds          (out_seconds),
    .out_wake_hours       (out_wake_hours),
    .out_wake_minutes     (out_wake_minutes),
    .out_armed            (out_armed),
    .out_ringing          (out_ringing),
    .mismatches           (mismatches),
    .outstanding          (outstanding)
  );

  always #2 clk = ~clk;

  // Synchronous reset, held low from the start and released on a falling edge.
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_hours        <= out_hours;
      seen_minutes      <= out_minutes;
      seen_wake_hours   <= out_wake_hours;
      seen_wake_minutes <= out_wake_minutes;
      seen_armed        <= out_armed;
    end
  end

  // Result side: before every transfer the receiver stalls for a random number of cycles,
  // then holds ready high until the transfer happens.
  initial begin : result_side
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!rst_n || out_valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offers one item after a random gap and returns at the edge where it is transferred.
  // With no gap, valid simply stays high and only the payload changes.
  task automatic send_item(input op_t op, input logic [ButtonW-1:0] raw);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_buttons   <= raw;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  // The buttons are ignored on a tick, so they carry noise there.
  task automatic send_tick();
    send_item(OpTick, ButtonW'($urandom));
  endtask

  task automatic send_buttons(input logic [ButtonW-1:0] pressed);
    send_item(OpButtons, ~pressed);
  endtask

  // Withdraws the input side and waits until every expected result has been transferred.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // The register is written only with the block idle: every result is out before the
  // write is offered.
  task automatic write_ticks(input logic [TickW-1:0] value);
    drain();
    repeat (2) @(negedge clk);
    cfg_valid            <= 1'b1;
    cfg_ticks_per_second <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    ticks_now = value;
  endtask

  // Sets the clock to the last minute of the hour (and of the day, if asked) and ticks
  // until the minutes roll over, which drives the carries through seconds, minutes and
  // possibly hours. Only worthwhile when a second takes very few ticks.
  task automatic roll_over(input bit whole_day);
    logic [ButtonW-1:0] pressed;
    int unsigned guard;
    drain();
    if (seen_armed) begin
      send_buttons(PressToggle);
      drain();
    end
    for (guard = 0; guard < 64; guard++) begin
      pressed = PressNone;
      if (whole_day && seen_hours != LastHour) pressed |= PressHour;
      if (seen_minutes != LastMinute) pressed |= PressMinute;
      if (pressed == PressNone) break;
      send_buttons(pressed);
      drain();
    end
    guard = 0;
    while (seen_minutes == LastMinute && guard < 64 * ticks_now + 64) begin
      send_tick();
      drain();
      guard++;
    end
  endtask

  // Arms the alarm and steps the wake-up time until it meets the current time, so that the
  // alarm rings. Matching times are otherwise far too rare under random stimulus.
  task automatic chase_alarm();
    logic [ButtonW-1:0] pressed;
    int unsigned guard;
    drain();
    if (!seen_armed) begin
      send_buttons(PressToggle);
      drain();
    end
    for (guard = 0; guard < 64; guard++) begin
      pressed = PressNone;
      if (seen_wake_hours != seen_hours) pressed |= PressHour;
      if (seen_wake_minutes != seen_minutes) pressed |= PressMinute;
      if (pressed == PressNone) break;
      send_buttons(pressed);
      drain();
    end
  endtask

  initial begin : stimulus
    logic [TickW-1:0]   settings [6];
    logic [ButtonW-1:0] pressed;
    int unsigned        phase;
    int unsigned        goal;
    int unsigned        pick;
    int unsigned        bitpos;

    while (!rst_n) @(negedge clk);

    // Directed part. At the reset rate a tick only moves the prescaler; a sample with
    // nothing pressed changes nothing either.
    send_item(OpTick, PressNone);
    send_buttons(PressNone);

    // The prescaler stands at one, so a register of two makes the next tick a second.
    write_ticks(TickW'(2));
    send_tick();
    // One tick per second from a cleared prescaler: with the second above, five ticks
    // carry 11:30:55 over into the next minute.
    write_ticks(TickW'(1));
    repeat (4) send_tick();
    // Everything pressed while disarmed steps hour and minute, clears the seconds and arms;
    // the same sample again, now armed, steps the alarm time and disarms (a held toggle).
    send_buttons(PressAll);
    send_buttons(PressAll);
    // Each button on its own, including clear while armed, which does nothing.
    send_buttons(PressToggle);
    send_buttons(PressClear);
    send_buttons(PressToggle);
    send_buttons(PressHour);
    send_buttons(PressMinute);
    send_buttons(PressClear);
    send_tick();

    // Extremes of the register: all ones, then zero, where the prescaler must wrap first.
    write_ticks('1);
    repeat (2) send_tick();
    write_ticks('0);
    repeat (2) send_tick();
    // The count is four here, so six is met on the second tick.
    write_ticks(TickW'(6));
    repeat (4) send_tick();

    // Lower the register below the running count, then tick back to back with no idling
    // on either side: the count climbs on past the register without a match.
    write_ticks(TickW'(20));
    repeat (10) send_tick();
    write_ticks(TickW'(5));
    no_idle = 1'b1;
    repeat (40) send_tick();
    drain();
    no_idle = 1'b0;
    // The count is now 52; a register of 53 brings it back to zero on the next tick, so
    // the short settings below start from a cleared prescaler.
    write_ticks(TickW'(53));
    send_tick();

    // Random part, in phases with different tick rates. Some phases run without gaps.
    // The short settings come first and in rising order, so each starts above the count.
    settings = '{TickW'(1), TickW'(2), TickW'(3), TickW'($urandom_range(4, 300)),
                 16'hFFFF, TickW'($urandom_range(1, 65535))};
    for (phase = 0; phase < 6; phase++) begin
      write_ticks(settings[phase]);
      no_idle = ($urandom_range(0, 3) == 0);
      goal = items_sent + PhaseItems;
      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 3 && ticks_now <= 3) begin
          roll_over($urandom_range(0, 1));
        end else if (pick < 6) begin
          chase_alarm();
        end else if (pick < 50) begin
          send_tick();
        end else if (pick < 92) begin
          pressed = PressNone;
          for (bitpos = 0; bitpos < ButtonW; bitpos++) begin
            if ($urandom_range(0, 2) == 0) pressed[bitpos] = 1'b1;
          end
          send_buttons(pressed);
        end else begin
          send_buttons(pick[0] ? PressAll : PressNone);
        end
      end
    end

    // Wait for the last results, then keep waiting for any stray transfer before the verdict.
    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("alarm_clock_counter_tb: PASS");
    end else begin
      $display("alarm_clock_counter_tb: FAIL");
    end
    $finish;
  end

  // Several times the slowest correct run; reaching it means the run has hung.
  initial begin : watchdog
    #3_000_000;
    $display("alarm_clock_counter_tb: FAIL");
    $finish;
  end

endmodule
